// ----- rtl/prec_pkg.sv -----
package prec_pkg;

	localparam int MvWidth   = 13;
	localparam int OffWidth  = 12;
	localparam int RecipBits = 18;
	localparam int RecipShift = 20;
	localparam int ProdWidth = OffWidth + RecipBits;

	localparam logic KIND_VOLTAGE = 1'b0;
	localparam logic KIND_CONTROL = 1'b1;

	localparam logic [3:0] NUM_BUCKS = 4'd5;
	localparam logic [3:0] NUM_RAILS = 4'd9;

	localparam logic [7:0] BUCK_VOUT_BASE = 8'h0E;
	localparam logic [7:0] BUCK_CTRL_BASE = 8'h04;
	localparam logic [7:0] LDO_VOUT_BASE  = 8'h23;
	localparam logic [7:0] LDO4_VOUT_ADDR = 8'h26;
	localparam logic [7:0] LDO_CTRL_BASE  = 8'h1D;

	localparam logic [7:0] CTRL_PULLDOWN = 8'h20;
	localparam logic [7:0] CTRL_ENABLE   = 8'h13;

	typedef enum logic [2:0] {
		DIV_5,
		DIV_10,
		DIV_20,
		DIV_25,
		DIV_50
	} div_sel_t;

	typedef struct packed {
		logic                err;
		logic                use_div;
		logic [7:0]          const_val;
		logic [OffWidth-1:0] off;
		div_sel_t            dsel;
		logic [7:0]          base;
		logic                shl;
		logic [7:0]          addr;
	} dec_t;

	// ceil(2^20 / d); exact for every offset below 4096
	function automatic logic [RecipBits-1:0] recip(input div_sel_t sel);
		logic [RecipBits-1:0] m;
		case (sel)
			DIV_5:   m = 18'd209716;
			DIV_10:  m = 18'd104858;
			DIV_20:  m = 18'd52429;
			DIV_25:  m = 18'd41944;
			DIV_50:  m = 18'd20972;
			default: m = 18'd0;
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/prec_decode.sv -----
module prec_decode (
	input  logic                            kind,
	input  logic [3:0]                      channel,
	input  logic [prec_pkg::MvWidth-1:0]    millivolts,
	input  logic                            enable,
	output prec_pkg::dec_t                  dec
);

	logic [prec_pkg::MvWidth-1:0] mv;
	logic [prec_pkg::MvWidth-1:0] diff;
	logic [1:0]                   ldo_idx;
	logic [7:0]                   buck_x2;

	assign mv      = millivolts;
	assign buck_x2 = {3'b000, channel, 1'b0};
	assign ldo_idx = 2'(channel - prec_pkg::NUM_BUCKS);

	always_comb begin
		dec           = '0;
		dec.dsel      = prec_pkg::DIV_5;
		diff          = '0;
		if (channel >= prec_pkg::NUM_RAILS) begin
			dec.err = 1'b1;
		end else if (kind == prec_pkg::KIND_CONTROL) begin
			if (channel < prec_pkg::NUM_BUCKS)
				dec.addr = prec_pkg::BUCK_CTRL_BASE + buck_x2;
			else
				dec.addr = prec_pkg::LDO_CTRL_BASE + {6'd0, ldo_idx};
			dec.const_val = enable ? (prec_pkg::CTRL_PULLDOWN | prec_pkg::CTRL_ENABLE)
			                       : prec_pkg::CTRL_PULLDOWN;
		end else if (channel < prec_pkg::NUM_BUCKS) begin
			dec.addr = prec_pkg::BUCK_VOUT_BASE + buck_x2;
			if (mv < 13'd300) begin
				dec.const_val = 8'h00;
			end else if (mv < 13'd600) begin
				diff = mv - 13'd300;
				dec.use_div = 1'b1;
				dec.dsel = prec_pkg::DIV_20;
				dec.base = 8'h00;
			end else if (mv < 13'd1100) begin
				diff = mv - 13'd600;
				dec.use_div = 1'b1;
				dec.dsel = prec_pkg::DIV_5;
				dec.base = 8'h0F;
			end else if (mv < 13'd1660) begin
				diff = mv - 13'd1100;
				dec.use_div = 1'b1;
				dec.dsel = prec_pkg::DIV_10;
				dec.base = 8'h73;
			end else if (mv < 13'd3340) begin
				diff = mv - 13'd1660;
				dec.use_div = 1'b1;
				dec.dsel = prec_pkg::DIV_20;
				dec.base = 8'hAB;
			end else begin
				dec.const_val = 8'hFF;
			end
		end else if (ldo_idx != 2'd3) begin
			dec.addr = prec_pkg::LDO_VOUT_BASE + {6'd0, ldo_idx};
			// code goes out shifted left one bit
			if (mv < 13'd600) begin
				dec.const_val = 8'h08;
			end else if (mv < 13'd3300) begin
				diff = mv - 13'd600;
				dec.use_div = 1'b1;
				dec.dsel = prec_pkg::DIV_50;
				dec.base = 8'h04;
				dec.shl = 1'b1;
			end else begin
				dec.const_val = 8'h74;
			end
		end else begin
			dec.addr = prec_pkg::LDO4_VOUT_ADDR;
			if (mv < 13'd1200) begin
				dec.const_val = 8'h20;
			end else if (mv < 13'd3300) begin
				diff = mv - 13'd1200;
				dec.use_div = 1'b1;
				dec.dsel = prec_pkg::DIV_25;
				dec.base = 8'h20;
			end else begin
				dec.const_val = 8'h74;
			end
		end
		dec.off = diff[prec_pkg::OffWidth-1:0];
	end

endmodule

// ----- rtl/pmic_rail_register_encoder_top.sv -----
// Rail register encoder: turns one rail request into a register address and
// the byte to write there.
//
// Input channel: in_valid / in_stall with kind, channel, millivolts, enable.
// Output channel: out_valid / out_stall with reg_address, reg_value, error.
// An item moves on a rising edge with valid high and stall low.
//
// Three register stages: decode and offset, reciprocal multiply, quotient
// add and select. One item per cycle is taken and delivered when the
// output is not stalled. Per-stage valid bits let an empty stage fill
// while the output is held, so in_stall only rises when all three stages
// hold items.
//
// Reset clears the valid bits; the pipeline comes up empty. While out_stall
// is high the output item holds; upstream stages keep filling until full.
// Channels 9 to 15 give error with address and value zero.
module pmic_rail_register_encoder_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic [3:0]                   channel,
	input  logic [prec_pkg::MvWidth-1:0] millivolts,
	input  logic                         enable,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   reg_address,
	output logic [7:0]                   reg_value,
	output logic                         error
);

	prec_pkg::dec_t dec;
	prec_pkg::dec_t dec_s1;

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	logic [prec_pkg::ProdWidth-1:0] prod_s2;
	logic [7:0]                     base_s2;
	logic                           shl_s2;
	logic                           use_div_s2;
	logic [7:0]                     const_s2;
	logic [7:0]                     addr_s2;
	logic                           err_s2;

	logic [7:0] quot;
	logic [7:0] sum;
	logic [7:0] val;

	logic [7:0] addr_s3;
	logic [7:0] val_s3;
	logic       err_s3;

	prec_decode u_decode (
		.kind       (kind),
		.channel    (channel),
		.millivolts (millivolts),
		.enable     (enable),
		.dec        (dec)
	);

	assign adv3     = !v_s3 || !out_stall;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= in_valid;
			if (adv2)
				v_s2 <= v_s1;
			if (adv3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1)
			dec_s1 <= dec;
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			prod_s2    <= dec_s1.off * prec_pkg::recip(dec_s1.dsel);
			base_s2    <= dec_s1.base;
			shl_s2     <= dec_s1.shl;
			use_div_s2 <= dec_s1.use_div;
			const_s2   <= dec_s1.const_val;
			addr_s2    <= dec_s1.addr;
			err_s2     <= dec_s1.err;
		end
	end

	// quotient always fits a byte for every segment
	assign quot = prod_s2[prec_pkg::RecipShift +: 8];
	assign sum  = quot + base_s2;
	assign val  = !use_div_s2 ? const_s2 : (shl_s2 ? {sum[6:0], 1'b0} : sum);

	always_ff @(posedge clk) begin
		if (adv3) begin
			addr_s3 <= addr_s2;
			val_s3  <= val;
			err_s3  <= err_s2;
		end
	end

	assign out_valid   = v_s3;
	assign reg_address = addr_s3;
	assign reg_value   = val_s3;
	assign error       = err_s3;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> reg_address == 8'd0 && reg_value == 8'd0)
		else $error("error item carries a nonzero address or value");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && v_s3)
		else $error("input stalled with an empty stage");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv2 |=> v_s1 && $stable(dec_s1))
		else $error("stage 1 item dropped or changed while blocked");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv3 |=> v_s2 && $stable(prod_s2) && $stable(addr_s2))
		else $error("stage 2 item dropped or changed while blocked");

endmodule
